/* design/pbl_pkg.sv */
// shared types and constants for the polygon boundary lattice counter
// used by pbl_ctrl, pbl_dp and polygon_boundary_lattice_count; no dependencies
package pbl_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int MAX_VERTICES   = 1024;
    localparam int COUNT_W        = 26;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_EDGE     = 5'b00100,
        S_CLOSE    = 5'b01000,
        S_EMIT     = 5'b10000
    } state_t;

    typedef struct packed {
        logic load_in;
        logic init_first;
        logic start_edge;
        logic edge_close;
        logic accumulate;
        logic commit_prev;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic have_prev;
        logic last;
        logic gcd_done;
        logic out_free;
    } status_t;

endpackage

/* design/polygon_boundary_lattice_count.sv */
// steps: the vertex is loaded, then dispatched; a first vertex only sets the start point,
// others run the gcd of their edge; a last vertex adds a second gcd for the closing edge,
// adds it and loads the output register once that is free; each gcd step removes one factor
// of two or does one subtract; one vertex at a time, a new one is taken only in idle
// the result waits in an output register while the next vertex is taken in
// reset: asynchronous active-low rst_n clears the sequencer, running total and output valid
module polygon_boundary_lattice_count #(
    parameter int COORD_BITS = pbl_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [COORD_BITS-1:0]  vertex_x,
    input  logic signed [COORD_BITS-1:0]  vertex_y,
    input  logic                          last_vertex,
    input  logic                          in_valid,
    output logic                          in_ready,
    output logic [pbl_pkg::COUNT_W-1:0]   boundary_points,
    output logic                          out_valid,
    input  logic                          out_ready
);

    pbl_pkg::cmd_t    cmd;
    pbl_pkg::status_t status;

    pbl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pbl_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .vertex_x        (vertex_x),
        .vertex_y        (vertex_y),
        .last_vertex     (last_vertex),
        .cmd             (cmd),
        .status          (status),
        .boundary_points (boundary_points),
        .out_valid       (out_valid),
        .out_ready       (out_ready)
    );

endmodule

/* design/pbl_ctrl.sv */
// sequencer for the polygon boundary lattice counter
// issues pbl_pkg::cmd_t commands to pbl_dp and reads back pbl_pkg::status_t
module pbl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pbl_pkg::status_t  status,
    output pbl_pkg::cmd_t     cmd
);

    pbl_pkg::state_t state_reg;
    pbl_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pbl_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == pbl_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            pbl_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = pbl_pkg::S_DISPATCH;
                end
            end
            pbl_pkg::S_DISPATCH:
            begin
                if (!status.have_prev)
                begin
                    // first vertex: no edge, a lone vertex closes to zero
                    cmd.init_first = 1'b1;
                    state_next     = status.last ? pbl_pkg::S_EMIT : pbl_pkg::S_IDLE;
                end
                else
                begin
                    cmd.start_edge = 1'b1;
                    state_next     = pbl_pkg::S_EDGE;
                end
            end
            pbl_pkg::S_EDGE:
            begin
                if (status.gcd_done)
                begin
                    cmd.accumulate  = 1'b1;
                    cmd.commit_prev = 1'b1;
                    if (status.last)
                    begin
                        // gcd unit reloads for the closing edge in the same cycle
                        cmd.start_edge = 1'b1;
                        cmd.edge_close = 1'b1;
                        state_next     = pbl_pkg::S_CLOSE;
                    end
                    else
                    begin
                        state_next = pbl_pkg::S_IDLE;
                    end
                end
            end
            pbl_pkg::S_CLOSE:
            begin
                if (status.gcd_done)
                begin
                    cmd.accumulate = 1'b1;
                    state_next     = pbl_pkg::S_EMIT;
                end
            end
            pbl_pkg::S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = pbl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pbl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* design/pbl_dp.sv */
// datapath: vertex registers, binary gcd unit, saturating total and output register
// driven by pbl_ctrl through pbl_pkg::cmd_t, reports pbl_pkg::status_t
module pbl_dp #(
    parameter int COORD_BITS = pbl_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [COORD_BITS-1:0]  vertex_x,
    input  logic signed [COORD_BITS-1:0]  vertex_y,
    input  logic                          last_vertex,
    input  pbl_pkg::cmd_t                 cmd,
    output pbl_pkg::status_t              status,
    output logic [pbl_pkg::COUNT_W-1:0]   boundary_points,
    output logic                          out_valid,
    input  logic                          out_ready
);

    localparam int     CW      = pbl_pkg::COUNT_W;
    localparam int     KW      = $clog2(COORD_BITS + 1);
    localparam int     SUM_W   = ((COORD_BITS > CW) ? COORD_BITS : CW) + 1;
    localparam longint RAW_LIM = longint'(pbl_pkg::MAX_VERTICES)
                                 * ((longint'(1) << COORD_BITS) - longint'(1));
    localparam longint OUT_MAX = (longint'(1) << CW) - longint'(1);
    localparam longint LIM     = (RAW_LIM > OUT_MAX) ? OUT_MAX : RAW_LIM;
    localparam logic [SUM_W-1:0] SAT_LIMIT = SUM_W'(LIM);

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_y_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic signed [COORD_BITS-1:0] first_x_reg, first_y_reg;
    logic                         last_reg;
    logic                         have_prev_reg;
    logic [CW-1:0]                total_reg;
    logic [CW-1:0]                out_reg;
    logic                         out_valid_reg;
    logic [COORD_BITS-1:0]        a_reg, b_reg;
    logic [KW-1:0]                k_reg;

    logic signed [COORD_BITS-1:0] ref_x, ref_y;
    logic signed [COORD_BITS:0]   dx, dy;
    logic [COORD_BITS-1:0]        abs_dx, abs_dy;
    logic                         gcd_done;
    logic [COORD_BITS-1:0]        gcd_val;
    logic [SUM_W-1:0]             sum;
    logic [CW-1:0]                total_sat;
    logic                         out_free;

    // the moving end is always the current vertex
    assign ref_x  = cmd.edge_close ? first_x_reg : prev_x_reg;
    assign ref_y  = cmd.edge_close ? first_y_reg : prev_y_reg;
    assign dx     = {cur_x_reg[COORD_BITS-1], cur_x_reg} - {ref_x[COORD_BITS-1], ref_x};
    assign dy     = {cur_y_reg[COORD_BITS-1], cur_y_reg} - {ref_y[COORD_BITS-1], ref_y};
    assign abs_dx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    assign abs_dy = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];

    assign gcd_done  = (a_reg == '0) || (b_reg == '0);
    assign gcd_val   = (a_reg | b_reg) << k_reg;
    assign sum       = SUM_W'(total_reg) + SUM_W'(gcd_val);
    assign total_sat = (sum > SAT_LIMIT) ? CW'(SAT_LIMIT) : sum[CW-1:0];
    assign out_free  = !out_valid_reg || out_ready;

    assign status.have_prev = have_prev_reg;
    assign status.last      = last_reg;
    assign status.gcd_done  = gcd_done;
    assign status.out_free  = out_free;

    assign boundary_points = out_reg;
    assign out_valid       = out_valid_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.init_first)
            begin
                have_prev_reg <= 1'b1;
                total_reg     <= '0;
            end
            else if (cmd.accumulate)
            begin
                total_reg <= total_sat;
            end
            else if (cmd.load_out)
            begin
                have_prev_reg <= 1'b0;
                total_reg     <= '0;
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cur_x_reg <= vertex_x;
            cur_y_reg <= vertex_y;
            last_reg  <= last_vertex;
        end
        if (cmd.init_first || cmd.commit_prev)
        begin
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
        end
        if (cmd.init_first)
        begin
            first_x_reg <= cur_x_reg;
            first_y_reg <= cur_y_reg;
        end
        if (cmd.load_out)
        begin
            out_reg <= total_reg;
        end
    end

    // binary gcd, one reduction step per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.start_edge)
        begin
            a_reg <= abs_dx;
            b_reg <= abs_dy;
            k_reg <= '0;
        end
        else if (!gcd_done)
        begin
            if (!a_reg[0] && !b_reg[0])
            begin
                a_reg <= a_reg >> 1;
                b_reg <= b_reg >> 1;
                k_reg <= k_reg + KW'(1);
            end
            else if (!a_reg[0])
            begin
                a_reg <= a_reg >> 1;
            end
            else if (!b_reg[0])
            begin
                b_reg <= b_reg >> 1;
            end
            else if (a_reg >= b_reg)
            begin
                a_reg <= a_reg - b_reg;
            end
            else
            begin
                b_reg <= b_reg - a_reg;
            end
        end
    end

endmodule

/* tb/pbl_boundary_checker.sv */
// checker for polygon_boundary_lattice_count: watches both channels, predicts
// each boundary count from the accepted vertices and compares in order; uses pbl_pkg
`timescale 1ns / 1ps
module pbl_boundary_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [15:0]            vertex_x,
    input  logic signed [15:0]            vertex_y,
    input  logic                          last_vertex,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [pbl_pkg::COUNT_W-1:0]   boundary_points,
    input  logic                          out_valid,
    input  logic                          out_ready,
    output int                            mismatches,
    output int                            pending,
    output int                            vertices,
    output int                            polygons
);

    localparam longint CAP_RAW   = longint'(pbl_pkg::MAX_VERTICES)
                                   * ((longint'(1) << pbl_pkg::COORD_BITS_DEF) - 1);
    localparam longint COUNT_MAX = (longint'(1) << pbl_pkg::COUNT_W) - 1;
    localparam longint TOTAL_CAP = (CAP_RAW > COUNT_MAX) ? COUNT_MAX : CAP_RAW;

    logic signed [15:0]            first_x = '0;
    logic signed [15:0]            first_y = '0;
    logic signed [15:0]            prev_x = '0;
    logic signed [15:0]            prev_y = '0;
    logic                          have_prev = 1'b0;
    longint                        running_total = 0;
    logic [pbl_pkg::COUNT_W-1:0]   expected_counts_q[$];
    int                            error_count = 0;
    int                            vertex_count = 0;
    int                            polygon_count = 0;

    // grid steps along one edge: gcd of the absolute coordinate differences
    function automatic longint lattice_steps(logic signed [15:0] ax, logic signed [15:0] ay,
                                             logic signed [15:0] bx, logic signed [15:0] by);
        longint a;
        longint b;
        longint t;
        a = longint'(ax) - longint'(bx);
        b = longint'(ay) - longint'(by);
        if (a < 0)
            a = -a;
        if (b < 0)
            b = -b;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic longint add_capped(longint total, longint steps);
        longint sum;
        sum = total + steps;
        return (sum > TOTAL_CAP) ? TOTAL_CAP : sum;
    endfunction

    always @(posedge clk)
    begin
        logic [pbl_pkg::COUNT_W-1:0] expected;
        if (rst_n)
        begin
            // result first: it can never belong to a vertex taken at this same edge
            if (out_valid && out_ready)
            begin
                polygon_count++;
                if (expected_counts_q.size() == 0)
                begin
                    if (error_count < 10)
                        $display("%0t: unexpected result boundary_points=%0d",
                                 $realtime, boundary_points);
                    error_count++;
                end
                else
                begin
                    expected = expected_counts_q.pop_front();
                    if (boundary_points !== expected)
                    begin
                        if (error_count < 10)
                            $display("%0t: boundary_points mismatch: expected %0d, got %0d",
                                     $realtime, expected, boundary_points);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                vertex_count++;
                if (!have_prev)
                begin
                    first_x = vertex_x;
                    first_y = vertex_y;
                    running_total = 0;
                    have_prev = 1'b1;
                end
                else
                    running_total = add_capped(running_total,
                        lattice_steps(prev_x, prev_y, vertex_x, vertex_y));
                prev_x = vertex_x;
                prev_y = vertex_y;
                if (last_vertex)
                begin
                    // closing edge back to the first vertex
                    running_total = add_capped(running_total,
                        lattice_steps(vertex_x, vertex_y, first_x, first_y));
                    expected_counts_q.push_back(running_total[pbl_pkg::COUNT_W-1:0]);
                    running_total = 0;
                    have_prev = 1'b0;
                end
            end
        end
        mismatches <= error_count;
        pending <= expected_counts_q.size();
        vertices <= vertex_count;
        polygons <= polygon_count;
    end

endmodule

/* tb/tb.sv */
// top of the polygon_boundary_lattice_count testbench: clock, reset, vertex stimulus
// and verdict; depends on pbl_pkg, the design and pbl_boundary_checker
`timescale 1ns / 1ps
module tb;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_VERTICES = 340;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic signed [15:0]            vertex_x = '0;
    logic signed [15:0]            vertex_y = '0;
    logic                          last_vertex = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          out_ready = 1'b0;
    wire                           in_ready;
    wire                           out_valid;
    wire [pbl_pkg::COUNT_W-1:0]    boundary_points;

    int send_idle_pct = 25;
    int recv_idle_pct = 80;
    int cycle_count = 0;
    int mismatches;
    int pending;
    int vertices;
    int polygons;

    polygon_boundary_lattice_count dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .vertex_x        (vertex_x),
        .vertex_y        (vertex_y),
        .last_vertex     (last_vertex),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .boundary_points (boundary_points),
        .out_valid       (out_valid),
        .out_ready       (out_ready)
    );

    pbl_boundary_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .vertex_x        (vertex_x),
        .vertex_y        (vertex_y),
        .last_vertex     (last_vertex),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .boundary_points (boundary_points),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .mismatches      (mismatches),
        .pending         (pending),
        .vertices        (vertices),
        .polygons        (polygons)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // valid is only dropped when an idle gap is taken, so it never toggles within one step
    task automatic send_vertex(input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic last);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        vertex_x <= x;
        vertex_y <= y;
        last_vertex <= last;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    function automatic logic signed [15:0] random_coord();
        int v;
        case ($urandom_range(4))
            0: v = $urandom_range(40) - 20;
            1: v = ($urandom_range(63) - 32) <<< $urandom_range(10);
            2:
            begin
                case ($urandom_range(3))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            default: v = $urandom;
        endcase
        return 16'(v);
    endfunction

    // random polygon, with repeated vertices now and then for degenerate edges
    task automatic send_polygon(input int count);
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] fx;
        logic signed [15:0] fy;
        for (int i = 0; i < count; i++)
        begin
            if (i == 0 || $urandom_range(9) != 0)
            begin
                x = random_coord();
                y = random_coord();
            end
            if (i == 0)
            begin
                fx = x;
                fy = y;
            end
            else if (i == count - 1 && $urandom_range(9) == 0)
            begin
                x = fx;
                y = fy;
            end
            send_vertex(x, y, i == count - 1);
        end
    endtask

    initial
    begin
        int phase_count;
        int n;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-vertex polygons, at the origin and at the extremes
        send_vertex(16'sd0, 16'sd0, 1'b1);
        send_vertex(-16'sd32768, 16'sd32767, 1'b1);
        // degenerate edge
        send_vertex(16'sd5, 16'sd5, 1'b0);
        send_vertex(16'sd5, 16'sd5, 1'b1);
        // full-range square
        send_vertex(-16'sd32768, -16'sd32768, 1'b0);
        send_vertex(16'sd32767, -16'sd32768, 1'b0);
        send_vertex(16'sd32767, 16'sd32767, 1'b0);
        send_vertex(-16'sd32768, 16'sd32767, 1'b1);
        // full-range diagonal
        send_vertex(-16'sd32768, -16'sd32768, 1'b0);
        send_vertex(16'sd32767, 16'sd32767, 1'b1);
        // coprime and common-factor triangles
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd3, 16'sd5, 1'b0);
        send_vertex(16'sd1, 16'sd2, 1'b1);
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd12, 16'sd18, 1'b0);
        send_vertex(-16'sd7, 16'sd30, 1'b1);
        // alternating bit patterns
        send_vertex(16'sh5555, -16'sh5556, 1'b0);
        send_vertex(-16'sh5556, 16'sh5555, 1'b1);
        // around the origin
        send_vertex(-16'sd1, -16'sd1, 1'b0);
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd1, 16'sd1, 1'b1);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 25;
                    recv_idle_pct = 80;
                end
                1:
                begin
                    send_idle_pct = 80;
                    recv_idle_pct = 25;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_count = 0;
            while (phase_count < PHASE_VERTICES)
            begin
                n = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 48);
                send_polygon(n);
                phase_count += n;
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("checked %0d vertices in %0d polygons: extremes, degenerate edges,",
                 vertices, polygons);
        $display("one-vertex polygons and three handshake phases; %0d mismatches", mismatches);
        if (mismatches == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
